// ===== src/mfd_pkg.sv =====
// Shared types, constants and the CRC-A byte update for the Miller frame decoder.
package mfd_pkg;

  localparam int unsigned NumW   = 19;  // 4*gap + round
  localparam int unsigned DenW   = 16;
  localparam logic [7:0]  QSat   = 8'hFF;
  localparam logic [15:0] CrcPre = 16'h6363;

  localparam logic [15:0] EtuReset   = 16'd679;
  localparam logic [15:0] RoundReset = 16'd339;

  // register indexes on the config port
  localparam logic RegEtu   = 1'b0;
  localparam logic RegRound = 1'b1;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q;
  } div_rsp_t;

  function automatic logic [15:0] crc_a_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] u;
    u = b ^ crc[7:0];
    u = u ^ {u[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {u, 8'h00} ^ {5'b00000, u, 3'b000} ^ {12'h000, u[7:4]};
  endfunction

endpackage

// ===== src/mfd_in_if.sv =====
// Input channel: edge or timeout events.
interface mfd_in_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [15:0] timestamp;

  modport source (output valid, event_kind, timestamp, input ready);
  modport sink   (input valid, event_kind, timestamp, output ready);
endinterface

// ===== src/mfd_out_if.sv =====
// Output channel: decoded frame bytes.
interface mfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [4:0] byte_index;
  logic       last_byte;
  logic       short_frame;
  logic       crc_checked;

  modport source (output valid, frame_byte, byte_index, last_byte, short_frame, crc_checked,
                  input ready);
  modport sink   (input valid, frame_byte, byte_index, last_byte, short_frame, crc_checked,
                  output ready);
endinterface

// ===== src/mfd_qdiv.sv =====
// Restoring divider, one quotient bit per cycle, result saturated to 8 bits.
module mfd_qdiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfd_pkg::div_req_t req_i,
  output mfd_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(mfd_pkg::NumW);

  logic                     busy_q, busy_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [mfd_pkg::DenW:0]   rem_q, rem_d;
  logic [mfd_pkg::NumW-1:0] num_q, num_d;
  logic [mfd_pkg::NumW-1:0] quo_q, quo_d;
  logic [mfd_pkg::DenW-1:0] den_q, den_d;
  logic                     done_q, done_d;
  logic [mfd_pkg::DenW:0]   rem_sh;
  logic                     fits;

  assign rem_sh = {rem_q[mfd_pkg::DenW-1:0], num_q[mfd_pkg::NumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      num_d  = req_i.num;
      quo_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_d = {num_q[mfd_pkg::NumW-2:0], 1'b0};
      quo_d = {quo_q[mfd_pkg::NumW-2:0], fits};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(mfd_pkg::NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = (|quo_q[mfd_pkg::NumW-1:8]) ? mfd_pkg::QSat : quo_q[7:0];

endmodule

// ===== src/iso14443a_miller_frame_decoder.sv =====
// Top level of the ISO 14443-A modified Miller frame decoder with CRC-A check.
//
// Each input beat is a rising-edge timestamp or a timeout. The block takes one
// beat at a time. An edge that goes through the divide is accepted, then waits
// on the bit-serial divider that turns the gap into quarter-bit units (a 19-bit
// quotient plus its done register), is decoded and, for a data gap, has one or
// two Miller bits shifted in. An edge skipped after a timeout is only accepted.
// A timeout, a wrapped gap or a zero etu ends the frame. At end of frame the
// frame store (a single-port synchronous RAM) is walked once for the CRC-A
// residue when it holds more than two bytes, reading then accumulating each
// byte, and, if the residue matches or the frame holds one or two bytes, once
// to emit bytes, reading then loading each; the input is held meanwhile. Output
// beats sit in a register, so the next byte is fetched while the previous one
// waits. A short frame is a single beat with short_frame set. Registers:
// etu_ticks at 0x0, round_ticks at 0x4.
module iso14443a_miller_frame_decoder #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  mfd_in_if.sink      in_i,
  mfd_out_if.source   out_o
);

  localparam int unsigned AW       = $clog2(FRAME_BYTES);
  localparam int unsigned CW       = $clog2(FRAME_BYTES + 1);
  localparam int unsigned MAX_EMIT = (FRAME_BYTES < 32) ? FRAME_BYTES : 32;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DIV     = 10'b0000000010,
    S_DEC     = 10'b0000000100,
    S_BITS    = 10'b0000001000,
    S_END     = 10'b0000010000,
    S_SHORT   = 10'b0000100000,
    S_CRC_RD  = 10'b0001000000,
    S_CRC_ACC = 10'b0010000000,
    S_EMIT_RD = 10'b0100000000,
    S_EMIT_LD = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [15:0] etu_q, etu_d, round_q, round_d;
  logic        cfg_we;

  // decoder state
  logic [15:0]   prev_q, prev_d;
  logic          skip_q, skip_d;
  logic          lmb_q, lmb_d;
  logic [7:0]    shift_q, shift_d;
  logic [3:0]    bitcnt_q, bitcnt_d;
  logic [CW-1:0] bytecnt_q, bytecnt_d;
  logic [7:0]    qv_q, qv_d;
  logic [1:0]    bits_q, bits_d;   // pending Miller bits, LSB first
  logic          nbits_q, nbits_d; // 1: two bits pending
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] nemit_q, nemit_d;
  logic [15:0]   crc_q, crc_d;
  logic          crc_ok_q, crc_ok_d; // flag for the frame being emitted

  // output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q, obyte_d;
  logic [4:0] oidx_q, oidx_d;
  logic       olast_q, olast_d, oshort_q, oshort_d, ocrc_q, ocrc_d;

  // frame store
  logic [7:0]    frame_store [FRAME_BYTES];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata_q;

  mfd_pkg::div_req_t div_req;
  mfd_pkg::div_rsp_t div_rsp;

  logic        accept, slot_free, cur_bit, parity;
  logic [15:0] crc_next;

  mfd_qdiv u_qdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // APB
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = {16'h0000, (paddr[2] == mfd_pkg::RegRound) ? round_q : etu_q};

  always_comb begin
    etu_d   = etu_q;
    round_d = round_q;
    if (cfg_we) begin
      if (paddr[2] == mfd_pkg::RegEtu) begin
        etu_d = pwdata[15:0];
      end else begin
        round_d = pwdata[15:0];
      end
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign slot_free  = !ovalid_q || out_o.ready;
  assign cur_bit    = bits_q[0];
  assign parity     = ^shift_q;
  assign crc_next   = mfd_pkg::crc_a_step(crc_q, mem_rdata_q);

  always_comb begin
    state_d   = state_q;
    prev_d    = prev_q;
    skip_d    = skip_q;
    lmb_d     = lmb_q;
    shift_d   = shift_q;
    bitcnt_d  = bitcnt_q;
    bytecnt_d = bytecnt_q;
    qv_d      = qv_q;
    bits_d    = bits_q;
    nbits_d   = nbits_q;
    idx_d     = idx_q;
    nemit_d   = nemit_q;
    crc_d     = crc_q;
    crc_ok_d  = crc_ok_q;
    ovalid_d  = ovalid_q && !out_o.ready;
    obyte_d   = obyte_q;
    oidx_d    = oidx_q;
    olast_d   = olast_q;
    oshort_d  = oshort_q;
    ocrc_d    = ocrc_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = idx_q[AW-1:0];
    div_req.start = 1'b0;
    div_req.num   = {1'b0, in_i.timestamp - prev_q, 2'b00} + {3'b000, round_q};
    div_req.den   = etu_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.event_kind) begin
            // timeout: treat as a saturated gap, then skip the next edge
            skip_d  = 1'b1;
            qv_d    = mfd_pkg::QSat;
            state_d = S_DEC;
          end else if (skip_q) begin
            skip_d = 1'b0;
            prev_d = in_i.timestamp;
          end else begin
            prev_d = in_i.timestamp;
            if (in_i.timestamp < prev_q || etu_q == 16'h0000) begin
              qv_d    = mfd_pkg::QSat;
              state_d = S_DEC;
            end else begin
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          qv_d    = div_rsp.q;
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        priority if (qv_q == 8'd4) begin
          bits_d  = {1'b0, lmb_q};
          nbits_d = 1'b0;
          state_d = S_BITS;
        end else if (qv_q == 8'd6) begin
          bits_d  = lmb_q ? 2'b00 : 2'b01;
          nbits_d = lmb_q;
          lmb_d   = !lmb_q;
          state_d = S_BITS;
        end else if (qv_q == 8'd8 && lmb_q) begin
          bits_d  = 2'b10;
          nbits_d = 1'b1;
          state_d = S_BITS;
        end else if (qv_q == 8'd8) begin
          state_d = S_END;
        end else begin
          lmb_d = 1'b0;
          if (qv_q > 8'd8) begin
            state_d = S_END;
          end else begin
            // abort
            shift_d   = '0;
            bitcnt_d  = '0;
            bytecnt_d = '0;
            state_d   = S_IDLE;
          end
        end
      end

      S_BITS: begin
        if (bitcnt_q[3]) begin
          // parity bit: odd parity over the byte
          if (parity != cur_bit) begin
            if (bytecnt_q < CW'(FRAME_BYTES)) begin
              mem_we    = 1'b1;
              mem_addr  = bytecnt_q[AW-1:0];
              bytecnt_d = bytecnt_q + CW'(1);
            end
          end else begin
            bytecnt_d = '0;
          end
          shift_d  = '0;
          bitcnt_d = '0;
        end else begin
          shift_d  = {cur_bit, shift_q[7:1]};
          bitcnt_d = bitcnt_q + 4'd1;
        end
        bits_d  = {1'b0, bits_q[1]};
        nbits_d = 1'b0;
        if (!nbits_q) begin
          state_d = S_IDLE;
        end
      end

      S_END: begin
        idx_d   = '0;
        crc_d   = mfd_pkg::CrcPre;
        nemit_d = (bytecnt_q > CW'(MAX_EMIT)) ? CW'(MAX_EMIT) : bytecnt_q;
        priority if (bitcnt_q == 4'd7) begin
          state_d = S_SHORT;
        end else if (bytecnt_q > CW'(2)) begin
          state_d = S_CRC_RD;
        end else if (bytecnt_q != '0) begin
          crc_ok_d = 1'b0;
          state_d  = S_EMIT_RD;
        end else begin
          shift_d  = '0;
          bitcnt_d = '0;
          state_d  = S_IDLE;
        end
      end

      S_SHORT: begin
        if (slot_free) begin
          ovalid_d  = 1'b1;
          obyte_d   = shift_q;
          oidx_d    = '0;
          olast_d   = 1'b1;
          oshort_d  = 1'b1;
          ocrc_d    = 1'b0;
          shift_d   = '0;
          bitcnt_d  = '0;
          bytecnt_d = '0;
          state_d   = S_IDLE;
        end
      end

      S_CRC_RD: begin
        mem_re  = 1'b1;
        state_d = S_CRC_ACC;
      end

      S_CRC_ACC: begin
        // running CRC over data and CRC bytes leaves zero on a match
        crc_d = crc_next;
        idx_d = idx_q + CW'(1);
        if (idx_q + CW'(1) == bytecnt_q) begin
          idx_d = '0;
          if (crc_next == 16'h0000) begin
            crc_ok_d = 1'b1;
            state_d  = S_EMIT_RD;
          end else begin
            shift_d   = '0;
            bitcnt_d  = '0;
            bytecnt_d = '0;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_CRC_RD;
        end
      end

      S_EMIT_RD: begin
        mem_re  = 1'b1;
        state_d = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          obyte_d  = mem_rdata_q;
          oidx_d   = 5'(idx_q);
          olast_d  = (idx_q + CW'(1) == nemit_q);
          oshort_d = 1'b0;
          ocrc_d   = crc_ok_q;
          idx_d    = idx_q + CW'(1);
          if (idx_q + CW'(1) == nemit_q) begin
            shift_d   = '0;
            bitcnt_d  = '0;
            bytecnt_d = '0;
            state_d   = S_IDLE;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      etu_q     <= mfd_pkg::EtuReset;
      round_q   <= mfd_pkg::RoundReset;
      prev_q    <= '0;
      skip_q    <= 1'b0;
      lmb_q     <= 1'b0;
      shift_q   <= '0;
      bitcnt_q  <= '0;
      bytecnt_q <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      etu_q     <= etu_d;
      round_q   <= round_d;
      prev_q    <= prev_d;
      skip_q    <= skip_d;
      lmb_q     <= lmb_d;
      shift_q   <= shift_d;
      bitcnt_q  <= bitcnt_d;
      bytecnt_q <= bytecnt_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qv_q     <= qv_d;
    bits_q   <= bits_d;
    nbits_q  <= nbits_d;
    idx_q    <= idx_d;
    nemit_q  <= nemit_d;
    crc_q    <= crc_d;
    crc_ok_q <= crc_ok_d;
    obyte_q  <= obyte_d;
    oidx_q   <= oidx_d;
    olast_q  <= olast_d;
    oshort_q <= oshort_d;
    ocrc_q   <= ocrc_d;
  end

  // frame store, single port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_store[mem_addr] <= shift_q;
    end
    if (mem_re) begin
      mem_rdata_q <= frame_store[mem_addr];
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.frame_byte  = obyte_q;
  assign out_o.byte_index  = oidx_q;
  assign out_o.last_byte   = olast_q;
  assign out_o.short_frame = oshort_q;
  assign out_o.crc_checked = ocrc_q;

endmodule
